### hdl/chim_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the chained hash id map.
// No dependencies; every other file imports this package.
package chim_pkg;

    localparam logic [1:0] OP_BIND    = 2'd0;
    localparam logic [1:0] OP_RESOLVE = 2'd1;
    localparam logic [1:0] OP_UNBIND  = 2'd2;
    localparam logic [1:0] OP_REMOVE  = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BOUND    = 2'd1;
    localparam logic [1:0] ST_NOMEM    = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] key;
        logic [31:0] value;
        logic [7:0]  handle;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] found_value;
        logic [7:0]  entry_handle;
    } rsp_t;

    // Fold the key slices into one 16-bit word.
    function automatic logic [15:0] key_fold(input logic [31:0] k);
        return k[15:0] ^ k[31:16];
    endfunction

endpackage

### hdl/chim_fold.sv
`timescale 1ns / 1ps
// Bucket index unit: folds a key and reduces it modulo the bucket count.
// Depends on chim_pkg. Power-of-two counts just mask the folded word.
module chim_fold #(
    parameter int BUCKETS = 64
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic [31:0]                           key,
    output logic                                  done,
    output logic [((BUCKETS > 1) ? $clog2(BUCKETS) : 1)-1:0] bucket
);
    import chim_pkg::*;

    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

    logic          done_reg;
    logic [BW-1:0] bucket_reg;

    assign done   = done_reg;
    assign bucket = bucket_reg;

    generate
        if ((BUCKETS & (BUCKETS - 1)) == 0) begin : g_mask
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    done_reg <= 1'b0;
                end
                else
                begin
                    done_reg <= start ? 1'b1 : done_reg;
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    bucket_reg <= BW'(key_fold(key) & 16'(BUCKETS - 1));
                end
            end
        end
        else begin : g_div
            // Remainder by reciprocal multiplication: latch the folded word,
            // form the quotient, then subtract quotient times bucket count.
            localparam int SH = 16 + BW;
            localparam longint MUL_L = ((longint'(1) << SH) + longint'(BUCKETS) - 1)
                                       / longint'(BUCKETS);
            localparam logic [17:0] MUL = 18'(MUL_L);

            localparam logic [1:0] F_IDLE = 2'd0;
            localparam logic [1:0] F_MUL  = 2'd1;
            localparam logic [1:0] F_BACK = 2'd2;

            logic [1:0]  step_reg;
            logic [15:0] word_reg;
            logic [15:0] quot_reg;
            logic [33:0] prod;
            logic [31:0] back;

            assign prod = {18'd0, word_reg} * {16'd0, MUL};
            assign back = {16'd0, quot_reg} * 32'(BUCKETS);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    done_reg <= 1'b0;
                    step_reg <= F_IDLE;
                end
                else if (start)
                begin
                    done_reg <= 1'b0;
                    step_reg <= F_MUL;
                end
                else if (step_reg == F_MUL)
                begin
                    step_reg <= F_BACK;
                end
                else if (step_reg == F_BACK)
                begin
                    step_reg <= F_IDLE;
                    done_reg <= 1'b1;
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    word_reg <= key_fold(key);
                end
                if (step_reg == F_MUL)
                begin
                    quot_reg <= 16'(prod >> SH);
                end
                if (step_reg == F_BACK)
                begin
                    bucket_reg <= BW'({16'd0, word_reg} - back);
                end
            end
        end
    endgenerate

endmodule

### hdl/chim_free_stack.sv
`timescale 1ns / 1ps
// Free entry stack: one synchronous memory and a fill count.
// Depends on chim_pkg. Filled with every index by the clearing pass.
module chim_free_stack #(
    parameter int ENTRIES = 256
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               clr_we,
    input  logic [$clog2(ENTRIES)-1:0]         clr_idx,
    input  logic                               rd_en,
    input  logic                               pop,
    input  logic                               push,
    input  logic [$clog2(ENTRIES)-1:0]         push_data,
    output logic [$clog2(ENTRIES+1)-1:0]       count,
    output logic [$clog2(ENTRIES)-1:0]         rd_data
);
    import chim_pkg::*;

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    logic [IW-1:0] stack_mem [ENTRIES];
    logic [CW-1:0] count_reg;
    logic [IW-1:0] rd_q;

    assign count   = count_reg;
    assign rd_data = rd_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= CW'(ENTRIES);
        end
        else if (pop)
        begin
            count_reg <= count_reg - CW'(1);
        end
        else if (push)
        begin
            count_reg <= count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_we)
        begin
            stack_mem[clr_idx] <= IW'(ENTRIES - 1) - clr_idx;
        end
        else if (push)
        begin
            stack_mem[IW'(count_reg)] <= push_data;
        end
        if (rd_en)
        begin
            rd_q <= stack_mem[IW'(count_reg - CW'(1))];
        end
    end

endmodule

### hdl/chim_engine.sv
`timescale 1ns / 1ps
// Operation sequencer with the bucket head and entry memories.
// Depends on chim_pkg; drives the bucket unit and the free stack.
module chim_engine #(
    parameter int ENTRIES    = 256,
    parameter int BUCKETS    = 64,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  req_valid,
    input  chim_pkg::req_t                        req,
    output logic                                  idle,
    output logic                                  clearing,
    output logic                                  res_valid,
    output chim_pkg::rsp_t                        res,
    input  logic                                  res_ack,
    output logic                                  fold_start,
    output logic [31:0]                           fold_key,
    input  logic                                  fold_done,
    input  logic [((BUCKETS > 1) ? $clog2(BUCKETS) : 1)-1:0] fold_bucket,
    output logic                                  stk_clr_we,
    output logic [$clog2(ENTRIES)-1:0]            stk_clr_idx,
    output logic                                  stk_rd_en,
    output logic                                  stk_pop,
    output logic                                  stk_push,
    output logic [$clog2(ENTRIES)-1:0]            stk_push_data,
    input  logic [$clog2(ENTRIES+1)-1:0]          stk_count,
    input  logic [$clog2(ENTRIES)-1:0]            stk_rd_data
);
    import chim_pkg::*;

    localparam int IW    = $clog2(ENTRIES);
    localparam int LW    = IW + 1;
    localparam int BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int KW    = (KEY_BITS < 32) ? KEY_BITS : 32;
    localparam int VW    = (VALUE_BITS < 32) ? VALUE_BITS : 32;
    localparam int CLR_N = (ENTRIES > BUCKETS) ? ENTRIES : BUCKETS;
    localparam int XW    = $clog2(CLR_N);
    localparam logic [LW-1:0] NONE = LW'(ENTRIES);

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_CACHE = 4'd2;
    localparam logic [3:0] S_RMCHK = 4'd3;
    localparam logic [3:0] S_HASH  = 4'd4;
    localparam logic [3:0] S_HEAD  = 4'd5;
    localparam logic [3:0] S_WALK  = 4'd6;
    localparam logic [3:0] S_POP   = 4'd7;
    localparam logic [3:0] S_LINK  = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    logic [LW-1:0] head_mem [BUCKETS];
    logic [KW-1:0] key_mem  [ENTRIES];
    logic [VW-1:0] val_mem  [ENTRIES];
    logic [LW-1:0] next_mem [ENTRIES];
    logic          live_mem [ENTRIES];

    logic [LW-1:0] head_q;
    logic [KW-1:0] key_q;
    logic [VW-1:0] val_q;
    logic [LW-1:0] next_q;
    logic          live_q;

    logic [3:0]    state_reg, state_next;
    logic [XW-1:0] clr_idx_reg, clr_idx_next;
    logic [LW-1:0] recent_reg, recent_next;
    logic [1:0]    op_reg, op_next;
    logic [KW-1:0] key_reg, key_next;
    logic [VW-1:0] val_reg, val_next;
    logic [IW-1:0] hnd_reg, hnd_next;
    logic [LW-1:0] cur_reg, cur_next;
    logic [LW-1:0] prev_reg, prev_next;
    rsp_t          res_reg, res_next;

    logic          head_we, head_re;
    logic [BW-1:0] head_waddr, head_raddr;
    logic [LW-1:0] head_wdata;
    logic          ent_re;
    logic [IW-1:0] ent_raddr;
    logic          kv_we;
    logic [IW-1:0] kv_waddr;
    logic          next_we;
    logic [IW-1:0] next_waddr;
    logic [LW-1:0] next_wdata;
    logic          live_we;
    logic [IW-1:0] live_waddr;
    logic          live_wdata;
    logic          miss;
    logic          hit;
    logic          hnd_ok;

    assign idle      = (state_reg == S_IDLE);
    assign clearing  = (state_reg == S_CLR);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    assign hnd_ok = ({24'd0, req.handle} < 32'(ENTRIES));
    assign hit    = (op_reg == OP_REMOVE) ? (cur_reg == LW'(hnd_reg)) : (key_q == key_reg);

    // Memories: one write and one registered read per array each cycle.
    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            head_mem[head_waddr] <= head_wdata;
        end
        if (head_re)
        begin
            head_q <= head_mem[head_raddr];
        end
        if (kv_we)
        begin
            key_mem[kv_waddr] <= key_reg;
            val_mem[kv_waddr] <= val_reg;
        end
        if (next_we)
        begin
            next_mem[next_waddr] <= next_wdata;
        end
        if (live_we)
        begin
            live_mem[live_waddr] <= live_wdata;
        end
        if (ent_re)
        begin
            key_q  <= key_mem[ent_raddr];
            val_q  <= val_mem[ent_raddr];
            next_q <= next_mem[ent_raddr];
            live_q <= live_mem[ent_raddr];
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_idx_next  = clr_idx_reg;
        recent_next   = recent_reg;
        op_next       = op_reg;
        key_next      = key_reg;
        val_next      = val_reg;
        hnd_next      = hnd_reg;
        cur_next      = cur_reg;
        prev_next     = prev_reg;
        res_next      = res_reg;
        head_we       = 1'b0;
        head_re       = 1'b0;
        head_waddr    = fold_bucket;
        head_raddr    = fold_bucket;
        head_wdata    = cur_reg;
        ent_re        = 1'b0;
        ent_raddr     = IW'(next_q);
        kv_we         = 1'b0;
        kv_waddr      = stk_rd_data;
        next_we       = 1'b0;
        next_waddr    = IW'(prev_reg);
        next_wdata    = cur_reg;
        live_we       = 1'b0;
        live_waddr    = IW'(cur_reg);
        live_wdata    = 1'b0;
        fold_start    = 1'b0;
        fold_key      = 32'(key_q);
        stk_clr_we    = 1'b0;
        stk_clr_idx   = IW'(clr_idx_reg);
        stk_rd_en     = 1'b0;
        stk_pop       = 1'b0;
        stk_push      = 1'b0;
        stk_push_data = IW'(cur_reg);
        miss          = 1'b0;

        unique case (state_reg)
            S_CLR:
            begin
                head_waddr = BW'(clr_idx_reg);
                head_wdata = NONE;
                head_we    = (32'(clr_idx_reg) < 32'(BUCKETS));
                live_waddr = IW'(clr_idx_reg);
                live_we    = (32'(clr_idx_reg) < 32'(ENTRIES));
                stk_clr_we = live_we;
                if (clr_idx_reg == XW'(CLR_N - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_idx_next = clr_idx_reg + XW'(1);
                end
            end
            S_IDLE:
            begin
                fold_key = 32'(KW'(req.key));
                if (req_valid)
                begin
                    op_next  = req.op;
                    key_next = KW'(req.key);
                    val_next = VW'(req.value);
                    hnd_next = IW'(req.handle);
                    case (req.op) inside
                        OP_BIND, OP_UNBIND:
                        begin
                            fold_start = 1'b1;
                            state_next = S_HASH;
                            if (req.op == OP_UNBIND)
                            begin
                                recent_next = NONE;
                            end
                        end
                        OP_RESOLVE:
                        begin
                            fold_start = 1'b1;
                            if (recent_reg != NONE)
                            begin
                                ent_re     = 1'b1;
                                ent_raddr  = IW'(recent_reg);
                                state_next = S_CACHE;
                            end
                            else
                            begin
                                state_next = S_HASH;
                            end
                        end
                        default:
                        begin
                            recent_next = NONE;
                            if (hnd_ok)
                            begin
                                ent_re     = 1'b1;
                                ent_raddr  = IW'(req.handle);
                                state_next = S_RMCHK;
                            end
                            else
                            begin
                                res_next   = '{ST_NOTFOUND, 32'd0, 8'd0};
                                state_next = S_DONE;
                            end
                        end
                    endcase
                end
            end
            S_CACHE:
            begin
                if (key_q == key_reg)
                begin
                    res_next   = '{ST_OK, 32'(val_q), 8'd0};
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_HASH;
                end
            end
            S_RMCHK:
            begin
                if (live_q)
                begin
                    fold_start = 1'b1;
                    state_next = S_HASH;
                end
                else
                begin
                    res_next   = '{ST_NOTFOUND, 32'd0, 8'd0};
                    state_next = S_DONE;
                end
            end
            S_HASH:
            begin
                if (fold_done)
                begin
                    head_re    = 1'b1;
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                prev_next = NONE;
                if (head_q == NONE)
                begin
                    miss = 1'b1;
                end
                else
                begin
                    ent_re     = 1'b1;
                    ent_raddr  = IW'(head_q);
                    cur_next   = head_q;
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (hit)
                begin
                    state_next = S_DONE;
                    case (op_reg)
                        OP_BIND:
                        begin
                            if (val_q == val_reg)
                            begin
                                res_next = '{ST_OK, 32'd0, 8'(cur_reg)};
                            end
                            else
                            begin
                                res_next = '{ST_BOUND, 32'd0, 8'd0};
                            end
                        end
                        OP_RESOLVE:
                        begin
                            recent_next = cur_reg;
                            res_next    = '{ST_OK, 32'(val_q), 8'd0};
                        end
                        default:
                        begin
                            // Unlink: splice around the entry and free it.
                            if (prev_reg == NONE)
                            begin
                                head_we    = 1'b1;
                                head_wdata = next_q;
                            end
                            else
                            begin
                                next_we    = 1'b1;
                                next_wdata = next_q;
                            end
                            live_we  = 1'b1;
                            stk_push = 1'b1;
                            res_next = '{ST_OK, 32'd0, 8'd0};
                        end
                    endcase
                end
                else
                begin
                    prev_next = cur_reg;
                    if (next_q == NONE)
                    begin
                        miss = 1'b1;
                    end
                    else
                    begin
                        ent_re   = 1'b1;
                        cur_next = next_q;
                    end
                end
            end
            S_POP:
            begin
                kv_we       = 1'b1;
                next_we     = 1'b1;
                next_waddr  = stk_rd_data;
                next_wdata  = NONE;
                live_we     = 1'b1;
                live_waddr  = stk_rd_data;
                live_wdata  = 1'b1;
                stk_pop     = 1'b1;
                recent_next = LW'(stk_rd_data);
                cur_next    = LW'(stk_rd_data);
                state_next  = S_LINK;
            end
            S_LINK:
            begin
                // Append at the tail; an empty chain takes the bucket head.
                if (prev_reg == NONE)
                begin
                    head_we = 1'b1;
                end
                else
                begin
                    next_we = 1'b1;
                end
                res_next   = '{ST_OK, 32'd0, 8'(cur_reg)};
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_ack)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (miss)
        begin
            if ((op_reg == OP_BIND) && (stk_count != '0))
            begin
                stk_rd_en  = 1'b1;
                state_next = S_POP;
            end
            else
            begin
                res_next   = '{((op_reg == OP_BIND) ? ST_NOMEM : ST_NOTFOUND), 32'd0, 8'd0};
                state_next = S_DONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLR;
            clr_idx_reg <= '0;
            recent_reg  <= NONE;
        end
        else
        begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            recent_reg  <= recent_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        key_reg  <= key_next;
        val_reg  <= val_next;
        hnd_reg  <= hnd_next;
        cur_reg  <= cur_next;
        prev_reg <= prev_next;
        res_reg  <= res_next;
    end

endmodule

### hdl/chained_hash_id_map.sv
`timescale 1ns / 1ps
// Chained hash id map: binds keys to values in a pool of ENTRIES entries kept
// in synchronous memories, with BUCKETS linked chains and a one-entry cache of
// the last bound or resolved entry. One operation runs at a time. After reset
// a clearing pass empties the bucket heads, the live bits and refills the free
// stack; req_stall stays high meanwhile. A resolve first checks a filled
// cache, a remove first checks that the entry is live, and a bind that
// allocates pops a free entry and then links it. With a bucket count that is
// not a power of two the bucket remainder unit takes three steps. Each chain
// step costs one entry memory read. A finished result sits in the rsp
// register, so the next word is taken while that result waits.
// Depends on chim_pkg, chim_fold, chim_free_stack and chim_engine.
module chained_hash_id_map #(
    parameter int ENTRIES    = 256,
    parameter int BUCKETS    = 64,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  chim_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output chim_pkg::rsp_t rsp
);
    import chim_pkg::*;

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

    logic          eng_idle;
    logic          eng_clearing;
    logic          eng_res_valid;
    rsp_t          eng_res;
    logic          res_ack;
    logic          fold_start;
    logic [31:0]   fold_key;
    logic          fold_done;
    logic [BW-1:0] fold_bucket;
    logic          stk_clr_we;
    logic [IW-1:0] stk_clr_idx;
    logic          stk_rd_en;
    logic          stk_pop;
    logic          stk_push;
    logic [IW-1:0] stk_push_data;
    logic [CW-1:0] stk_count;
    logic [IW-1:0] stk_rd_data;
    logic          rsp_valid_reg;
    rsp_t          rsp_reg;

    // Take a request word only while the sequencer is idle.
    assign req_stall = !eng_idle;

    // Hand a result over when the output register is empty or draining.
    assign res_ack   = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    chim_engine #(
        .ENTRIES    (ENTRIES),
        .BUCKETS    (BUCKETS),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req           (req),
        .idle          (eng_idle),
        .clearing      (eng_clearing),
        .res_valid     (eng_res_valid),
        .res           (eng_res),
        .res_ack       (res_ack),
        .fold_start    (fold_start),
        .fold_key      (fold_key),
        .fold_done     (fold_done),
        .fold_bucket   (fold_bucket),
        .stk_clr_we    (stk_clr_we),
        .stk_clr_idx   (stk_clr_idx),
        .stk_rd_en     (stk_rd_en),
        .stk_pop       (stk_pop),
        .stk_push      (stk_push),
        .stk_push_data (stk_push_data),
        .stk_count     (stk_count),
        .stk_rd_data   (stk_rd_data)
    );

    chim_fold #(
        .BUCKETS (BUCKETS)
    ) u_fold (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (fold_start),
        .key    (fold_key),
        .done   (fold_done),
        .bucket (fold_bucket)
    );

    chim_free_stack #(
        .ENTRIES (ENTRIES)
    ) u_free_stack (
        .clk       (clk),
        .rst_n     (rst_n),
        .clr_we    (stk_clr_we),
        .clr_idx   (stk_clr_idx),
        .rd_en     (stk_rd_en),
        .pop       (stk_pop),
        .push      (stk_push),
        .push_data (stk_push_data),
        .count     (stk_count),
        .rd_data   (stk_rd_data)
    );

    // Output register: hold the word until the consumer takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (eng_res_valid && res_ack)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (eng_res_valid && res_ack)
        begin
            rsp_reg <= eng_res;
        end
    end

    // Free count never exceeds the pool size.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stk_count <= CW'(ENTRIES))
        else $error("free count above pool size");

    // No request word is taken during the clearing pass.
    a_clear_stall: assert property (@(posedge clk) disable iff (!rst_n)
        eng_clearing |-> req_stall)
        else $error("request taken while clearing");

    // No memory is reported only with an empty free stack.
    a_nomem: assert property (@(posedge clk) disable iff (!rst_n)
        (eng_res_valid && (eng_res.status == ST_NOMEM)) |-> (stk_count == '0))
        else $error("no memory with free entries left");

    // A finished result waits unchanged until the output register takes it.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (eng_res_valid && !res_ack) |=> (eng_res_valid && $stable(eng_res)))
        else $error("result dropped before hand-over");

endmodule

### test/chained_hash_id_map_checker.sv
`timescale 1ns / 1ps
// Checker for the chained hash id map: tracks the map state from accepted
// request words and compares each response word. Depends on chim_pkg.
module chained_hash_id_map_checker
    import chim_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  req_valid,
    input  logic  req_stall,
    input  req_t  req,
    input  logic  rsp_valid,
    input  logic  rsp_stall,
    input  rsp_t  rsp,
    output int    fail_count,
    output int    pending
);

    localparam int NENT = 256;
    localparam int NBKT = 64;
    localparam int NIL  = NENT;

    int          head_of [NBKT];
    logic [31:0] ent_key [NENT];
    logic [31:0] ent_val [NENT];
    int          ent_next [NENT];
    bit          ent_live [NENT];
    int          free_lifo [NENT];
    int          free_n;
    int          recent;
    rsp_t        expected_q [$];

    function automatic int bucket_index(logic [31:0] k);
        logic [15:0] f;
        f = k[15:0] ^ k[31:16];
        return int'(f) % NBKT;
    endfunction

    function automatic int lookup(int b, logic [31:0] k, output int tail);
        int cur;
        cur = head_of[b];
        tail = NIL;
        while (cur != NIL)
        begin
            if (ent_key[cur] == k)
                return cur;
            tail = cur;
            cur = ent_next[cur];
        end
        return NIL;
    endfunction

    function automatic bit detach(int b, int target);
        int prev;
        int cur;
        prev = NIL;
        cur = head_of[b];
        while (cur != NIL)
        begin
            if (cur == target)
            begin
                if (prev == NIL)
                    head_of[b] = ent_next[cur];
                else
                    ent_next[prev] = ent_next[cur];
                ent_live[cur] = 0;
                free_lifo[free_n] = cur;
                free_n++;
                return 1;
            end
            prev = cur;
            cur = ent_next[cur];
        end
        return 0;
    endfunction

    function automatic rsp_t apply_op(req_t r);
        rsp_t o;
        int b;
        int e;
        int tail;
        o = '0;
        o.status = ST_NOTFOUND;
        b = bucket_index(r.key);
        case (r.op)
            OP_BIND:
            begin
                e = lookup(b, r.key, tail);
                if (e != NIL)
                begin
                    if (ent_val[e] == r.value)
                    begin
                        o.status = ST_OK;
                        o.entry_handle = e[7:0];
                    end
                    else
                        o.status = ST_BOUND;
                end
                else if (free_n == 0)
                    o.status = ST_NOMEM;
                else
                begin
                    free_n--;
                    e = free_lifo[free_n];
                    ent_key[e] = r.key;
                    ent_val[e] = r.value;
                    ent_next[e] = NIL;
                    ent_live[e] = 1;
                    recent = e;
                    if (tail != NIL)
                        ent_next[tail] = e;
                    else
                        head_of[b] = e;
                    o.status = ST_OK;
                    o.entry_handle = e[7:0];
                end
            end
            OP_RESOLVE:
            begin
                if (recent != NIL && ent_key[recent] == r.key)
                begin
                    o.status = ST_OK;
                    o.found_value = ent_val[recent];
                end
                else
                begin
                    e = lookup(b, r.key, tail);
                    if (e != NIL)
                    begin
                        recent = e;
                        o.status = ST_OK;
                        o.found_value = ent_val[e];
                    end
                end
            end
            OP_UNBIND:
            begin
                recent = NIL;
                e = lookup(b, r.key, tail);
                if (e != NIL && detach(b, e))
                    o.status = ST_OK;
            end
            default:
            begin
                recent = NIL;
                if (ent_live[r.handle])
                    if (detach(bucket_index(ent_key[r.handle]), int'(r.handle)))
                        o.status = ST_OK;
            end
        endcase
        return o;
    endfunction

    assign pending = expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NBKT; i++)
                head_of[i] = NIL;
            for (int i = 0; i < NENT; i++)
            begin
                ent_next[i] = NIL;
                ent_live[i] = 0;
                free_lifo[i] = NENT - 1 - i;
            end
            free_n = NENT;
            recent = NIL;
            expected_q.delete();
            fail_count <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("response word with nothing expected");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (rsp.status !== want.status)
                        $error("status: expected %0d actual %0d", want.status, rsp.status);
                    if (rsp.found_value !== want.found_value)
                        $error("found_value: expected %h actual %h",
                               want.found_value, rsp.found_value);
                    if (rsp.entry_handle !== want.entry_handle)
                        $error("entry_handle: expected %0d actual %0d",
                               want.entry_handle, rsp.entry_handle);
                    if (rsp !== want)
                        fail_count <= fail_count + 1;
                end
            end
            if (req_valid && !req_stall)
                expected_q.push_back(apply_op(req));
        end
    end

endmodule

### test/chained_hash_id_map_tb.sv
`timescale 1ns / 1ps
// Top of the chained hash id map test: clock, reset, request stimulus and
// response back-pressure. Depends on chim_pkg, the block and the checker.
module chained_hash_id_map_tb;
    import chim_pkg::*;

    logic clk = 0;
    logic rst_n = 0;
    logic req_valid = 0;
    logic req_stall;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 0;
    rsp_t rsp;
    int   fail_count;
    int   pending;

    // Keep a small pool of keys so that binds collide and chains grow.
    logic [31:0] key_pool [32];
    bit   calm = 0;      // no idling on either side near the end
    bit   hold_rsp = 0;  // long receiver hold-off in progress

    always #10 clk = ~clk;

    chained_hash_id_map u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    chained_hash_id_map_checker u_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Offer one word and hold it until the block takes it; sometimes idle
    // first, but never when calm.
    task automatic send_word(logic [1:0] op, logic [31:0] k, logic [31:0] v,
                             logic [7:0] h);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 14);
        repeat (gap)
        begin
            @(posedge clk);
            req_valid <= 0;
        end
        @(posedge clk);
        req_valid <= 1;
        req.op <= op;
        req.key <= k;
        req.value <= v;
        req.handle <= h;
        do
            @(posedge clk);
        while (!(req_valid && !req_stall));
        req_valid <= 0;
    endtask

    function automatic logic [31:0] pick_key();
        if ($urandom_range(0, 9) == 0)
            return $urandom();
        return key_pool[$urandom_range(0, 31)];
    endfunction

    // Receiver: random stall bursts, one long hold-off on request, none when calm.
    initial
    begin
        int n;
        forever
        begin
            @(posedge clk);
            if (hold_rsp)
                rsp_stall <= 1;
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                n = $urandom_range(1, 14);
                rsp_stall <= 1;
                repeat (n - 1)
                    @(posedge clk);
                @(posedge clk);
                rsp_stall <= 0;
            end
            else
                rsp_stall <= 0;
        end
    end

    initial
    begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        int settle;
        for (int i = 0; i < 32; i++)
            key_pool[i] = (i < 8) ? {16'(i), 16'(i * 64)} : $urandom();
        repeat (10)
            @(posedge clk);
        rst_n <= 1;

        // Directed: field extremes, every op, cache hits and misses.
        send_word(OP_RESOLVE, 32'h0, 32'h0, 8'h0);
        send_word(OP_BIND, 32'h0, 32'h0, 8'h0);
        send_word(OP_BIND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
        send_word(OP_BIND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h0);
        send_word(OP_BIND, 32'hFFFF_FFFF, 32'h1234_5678, 8'h0);
        send_word(OP_RESOLVE, 32'hFFFF_FFFF, 32'h0, 8'h0);
        send_word(OP_RESOLVE, 32'h0, 32'h0, 8'h0);
        send_word(OP_BIND, key_pool[1], 32'hA5A5_A5A5, 8'h0);
        send_word(OP_BIND, key_pool[2], 32'h5A5A_5A5A, 8'h0);
        send_word(OP_RESOLVE, key_pool[1], 32'h0, 8'h0);
        send_word(OP_UNBIND, key_pool[1], 32'h0, 8'h0);
        send_word(OP_UNBIND, key_pool[1], 32'h0, 8'h0);
        send_word(OP_RESOLVE, key_pool[2], 32'h0, 8'h0);
        send_word(OP_REMOVE, 32'h0, 32'h0, 8'd0);
        send_word(OP_REMOVE, 32'h0, 32'h0, 8'd0);
        send_word(OP_REMOVE, 32'h0, 32'h0, 8'hFF);
        send_word(OP_BIND, key_pool[3], 32'h1, 8'h0);

        // Fill the pool to exhaustion, stalling the receiver meanwhile so the
        // block backs up its input.
        hold_rsp = 1;
        fork
            begin
                repeat (300)
                    @(posedge clk);
                hold_rsp = 0;
            end
        join_none
        for (int i = 0; i < 260; i++)
            send_word(OP_BIND, $urandom(), $urandom(), 8'h0);
        send_word(OP_BIND, key_pool[5], 32'h7, 8'h0);
        for (int i = 0; i < 256; i++)
            send_word(OP_REMOVE, 32'h0, 32'h0, i[7:0]);

        // Random: mostly pool keys so binds hit, conflict and chain.
        for (int i = 0; i < 416; i++)
        begin
            if (i == 340)
                calm = 1;
            send_word(2'($urandom_range(0, 3)), pick_key(),
                      ($urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom()),
                      8'($urandom_range(0, 255)));
        end

        settle = 0;
        while (pending != 0 && settle < 100000)
        begin
            @(posedge clk);
            settle++;
        end
        repeat (50)
            @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### filelist.f
hdl/chim_pkg.sv
hdl/chim_fold.sv
hdl/chim_free_stack.sv
hdl/chim_engine.sv
hdl/chained_hash_id_map.sv
test/chained_hash_id_map_checker.sv
test/chained_hash_id_map_tb.sv
